### sv/rbst_pkg.sv
package rbst_pkg;

  // Coordinate format: signed Q(COORD_WIDTH-FRAC_BITS).FRAC_BITS
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  // Field widths and stream widths
  localparam int AXIS_WIDTH    = 2;
  localparam int IN_BITS       = AXIS_WIDTH + 6 * COORD_WIDTH;
  localparam int S_TDATA_WIDTH = ((IN_BITS + 7) / 8) * 8;
  localparam int M_TDATA_WIDTH = 8;

  // Axis codes
  localparam logic [AXIS_WIDTH-1:0] AXIS_X    = 2'd0;
  localparam logic [AXIS_WIDTH-1:0] AXIS_Y    = 2'd1;
  localparam logic [AXIS_WIDTH-1:0] AXIS_Z    = 2'd2;
  localparam logic [AXIS_WIDTH-1:0] AXIS_NONE = 2'd3;

  // Saturation limits
  localparam logic [COORD_WIDTH-1:0] Q_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] Q_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV_LOW,
    S_DIV_HIGH,
    S_SORT,
    S_TIGHTEN,
    S_CHECK,
    S_EMIT
  } state_t;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### sv/ray_box_slab_test_top.sv
// Ray against axis-aligned box slab test. Send one transfer per axis in x, y, z order; the
// x transfer loads the ray interval and starts a new test, the z transfer yields one result
// transfer carrying the hit flag, and axis code 3 is dropped. Each axis runs two signed
// Q16.16 divisions (slab low and high crossing) on one shared radix-2 divider, one quotient
// bit per cycle; after setup, the divisions, ordering, interval update and miss check, the
// block returns to idle, and s_tready is high only while it is idle, so no new item is taken
// before the last one is through. A zero direction skips the divisions. A pending result
// waits in the output register while the next item is accepted; a z item stalls only if the
// previous result has not been taken.
module ray_box_slab_test_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // axis_index, box_low, box_high, ray_origin, ray_direction, interval_start,
  // interval_end, zero fill
  input  logic [rbst_pkg::S_TDATA_WIDTH-1:0]    s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // hit, zero fill
  output logic [rbst_pkg::M_TDATA_WIDTH-1:0]    m_tdata
);

  localparam int CW = rbst_pkg::COORD_WIDTH;
  localparam int AW = rbst_pkg::AXIS_WIDTH;

  rbst_pkg::state_t      state;
  rbst_pkg::state_t      state_next;
  rbst_pkg::div_status_t div_stat;

  logic [AW-1:0]        axis;
  logic signed [CW-1:0] box_low;
  logic signed [CW-1:0] box_high;
  logic signed [CW-1:0] ray_origin;
  logic signed [CW-1:0] ray_direction;
  logic signed [CW-1:0] near_distance;
  logic signed [CW-1:0] far_distance;
  logic signed [CW-1:0] t0;
  logic signed [CW-1:0] t1;
  logic                 miss_latched;
  logic                 hit;

  logic                 s_xfer;
  logic [AW-1:0]        in_axis;
  logic                 dir_zero;
  logic                 out_load;
  logic                 div_start;
  logic signed [CW:0]   div_num;
  logic [CW-1:0]        div_quot;

  assign s_xfer   = s_tvalid & s_tready;
  assign in_axis  = s_tdata[AW-1:0];
  assign dir_zero = (ray_direction == '0);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      rbst_pkg::S_IDLE: begin
        if (s_xfer && in_axis != rbst_pkg::AXIS_NONE) state_next = rbst_pkg::S_PREP;
      end
      rbst_pkg::S_PREP: begin
        state_next = dir_zero ? rbst_pkg::S_CHECK : rbst_pkg::S_DIV_LOW;
      end
      rbst_pkg::S_DIV_LOW: begin
        if (div_stat.done) state_next = rbst_pkg::S_DIV_HIGH;
      end
      rbst_pkg::S_DIV_HIGH: begin
        if (div_stat.done) state_next = rbst_pkg::S_SORT;
      end
      rbst_pkg::S_SORT:    state_next = rbst_pkg::S_TIGHTEN;
      rbst_pkg::S_TIGHTEN: state_next = rbst_pkg::S_CHECK;
      rbst_pkg::S_CHECK: begin
        state_next = (axis == rbst_pkg::AXIS_Z) ? rbst_pkg::S_EMIT : rbst_pkg::S_IDLE;
      end
      rbst_pkg::S_EMIT: begin
        if (!m_tvalid || m_tready) state_next = rbst_pkg::S_IDLE;
      end
      default: state_next = rbst_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    div_num   = {box_high[CW-1], box_high} - {ray_origin[CW-1], ray_origin};
    unique case (state)
      rbst_pkg::S_IDLE: s_tready = 1'b1;
      rbst_pkg::S_PREP: begin
        div_start = !dir_zero;
        div_num   = {box_low[CW-1], box_low} - {ray_origin[CW-1], ray_origin};
      end
      rbst_pkg::S_DIV_LOW: div_start = div_stat.done;
      rbst_pkg::S_EMIT:    out_load  = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  // Shared divider
  rbst_divider u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_num),
    .den    (ray_direction),
    .status (div_stat),
    .quot   (div_quot)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbst_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the item's fields
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      axis          <= in_axis;
      box_low       <= s_tdata[AW +: CW];
      box_high      <= s_tdata[AW + CW +: CW];
      ray_origin    <= s_tdata[AW + 2*CW +: CW];
      ray_direction <= s_tdata[AW + 3*CW +: CW];
    end
  end

  // Hold slab crossings, ordered before the interval update
  always_ff @(posedge clk) begin
    if (state == rbst_pkg::S_DIV_LOW && div_stat.done) t0 <= div_quot;
    if (state == rbst_pkg::S_DIV_HIGH && div_stat.done) t1 <= div_quot;
    if (state == rbst_pkg::S_SORT && t0 > t1) begin
      t0 <= t1;
      t1 <= t0;
    end
  end

  // Running interval and miss latch
  always_ff @(posedge clk) begin
    if (rst) begin
      near_distance <= '0;
      far_distance  <= '0;
      miss_latched  <= 1'b0;
    end else begin
      if (s_xfer && in_axis == rbst_pkg::AXIS_X) begin
        near_distance <= s_tdata[AW + 4*CW +: CW];
        far_distance  <= s_tdata[AW + 5*CW +: CW];
        miss_latched  <= 1'b0;
      end
      if (state == rbst_pkg::S_PREP && dir_zero &&
          (ray_origin < box_low || ray_origin > box_high)) begin
        miss_latched <= 1'b1;
      end
      if (state == rbst_pkg::S_TIGHTEN) begin
        if (t0 > near_distance) near_distance <= t0;
        if (t1 < far_distance) far_distance <= t1;
      end
      if (state == rbst_pkg::S_CHECK && far_distance <= near_distance) begin
        miss_latched <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) hit <= !miss_latched;
  end

  assign m_tdata = {{(rbst_pkg::M_TDATA_WIDTH-1){1'b0}}, hit};

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == rbst_pkg::S_DIV_LOW || state == rbst_pkg::S_DIV_HIGH))
    else $error("divider result outside a division state");
  a_miss_check: assert property (@(posedge clk) disable iff (rst)
    (state == rbst_pkg::S_CHECK && far_distance <= near_distance) |=> miss_latched)
    else $error("empty interval did not latch a miss");
  a_result_from_z: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (axis == rbst_pkg::AXIS_Z))
    else $error("result produced for an item other than z");
`endif

endmodule

### sv/rbst_divider.sv
module rbst_divider (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic signed [rbst_pkg::COORD_WIDTH:0]  num,
  input  logic signed [rbst_pkg::COORD_WIDTH-1:0] den,
  output rbst_pkg::div_status_t                  status,
  output logic [rbst_pkg::COORD_WIDTH-1:0]       quot
);

  localparam int CW    = rbst_pkg::COORD_WIDTH;
  localparam int FB    = rbst_pkg::FRAC_BITS;
  // Dividend bits above this position can produce no quotient bit without overflow
  localparam int SKIP  = CW + 1 - FB;
  localparam int CNT_W = $clog2(CW + 2);

  logic             busy;
  logic             finish;
  logic             done;
  logic [CNT_W-1:0] count;
  logic [CW-1:0]    rem;
  logic [CW-1:0]    dmag;
  logic [CW:0]      shift_in;
  logic [CW:0]      q;
  logic             neg;
  logic             ovf;

  logic [CW:0]      a_abs;
  logic [CW-1:0]    d_abs;
  logic             ovf_next;
  logic [CW:0]      rem_shift;
  logic [CW:0]      rem_diff;
  logic             rem_ge;
  logic             sat;

  // Magnitudes and early overflow check for the full Q quotient
  always_comb begin
    a_abs    = num[CW] ? (CW+1)'(-num) : num;
    d_abs    = den[CW-1] ? CW'(-den) : den;
    ovf_next = ({{(SKIP-1){1'b0}}, a_abs} >= {d_abs, {SKIP{1'b0}}});
  end

  // One restoring step: bring in the next dividend bit, subtract if it fits
  always_comb begin
    rem_shift = {rem, shift_in[CW]};
    rem_diff  = rem_shift - {1'b0, dmag};
    rem_ge    = (rem_shift >= {1'b0, dmag});
    sat       = ovf | q[CW] | q[CW-1];
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      finish <= 1'b0;
      done   <= 1'b0;
      count  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(CW + 1);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy   <= 1'b0;
          finish <= 1'b1;
        end
      end else if (finish) begin
        finish <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dmag     <= d_abs;
      neg      <= num[CW] ^ den[CW-1];
      ovf      <= ovf_next;
      rem      <= {{(CW-FB){1'b0}}, a_abs[CW:SKIP]};
      shift_in <= {a_abs[SKIP-1:0], {FB{1'b0}}};
      q        <= '0;
    end else if (busy) begin
      rem      <= rem_ge ? rem_diff[CW-1:0] : rem_shift[CW-1:0];
      shift_in <= {shift_in[CW-1:0], 1'b0};
      q        <= {q[CW-1:0], rem_ge};
    end
    // Saturate and apply the sign
    if (finish) begin
      if (neg) begin
        quot <= sat ? rbst_pkg::Q_MIN : CW'(-q[CW-1:0]);
      end else begin
        quot <= sat ? rbst_pkg::Q_MAX : q[CW-1:0];
      end
    end
  end

  assign status.busy = busy | finish;
  assign status.done = done;

`ifndef SYNTH
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held longer than one cycle");
  a_busy_count: assert property (@(posedge clk) disable iff (rst)
    busy |-> (count != '0))
    else $error("divider iterating with zero step count");
  a_finish_after: assert property (@(posedge clk) disable iff (rst)
    $rose(finish) |-> $past(busy) && $past(count == CNT_W'(1)))
    else $error("divider finished early");
`endif

endmodule
